// File: hdl/sm4_pkg.sv
// SM4 package: S-box, system parameters and round constant helper.
package sm4_pkg;

    localparam int unsigned ROUND_COUNT = 32;
    localparam int unsigned ROUND_IDX_W = $clog2(ROUND_COUNT);

    localparam logic [31:0] FK0 = 32'ha3b1bac6;
    localparam logic [31:0] FK1 = 32'h56aa3350;
    localparam logic [31:0] FK2 = 32'h677d9197;
    localparam logic [31:0] FK3 = 32'hb27022dc;

    localparam logic [7:0] SBOX [256] = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

    typedef logic [31:0] word_t;
    typedef logic [ROUND_IDX_W-1:0] round_idx_t;

    typedef enum logic {
        MIX_DATA = 1'b0,
        MIX_KEY  = 1'b1
    } mix_sel_t;

    function automatic word_t ck_word(input round_idx_t idx);
        logic [9:0] pos;
        word_t      w;
        w = '0;
        for (int j = 0; j < 4; j++) begin
            pos = 10'({idx, 2'(j)}) * 10'd7;
            w[31-8*j -: 8] = pos[7:0];
        end
        return w;
    endfunction

endpackage

// File: hdl/sm4_round.sv
// SM4 shared round function: S-box layer and linear mix for data or key schedule.
module sm4_round
    import sm4_pkg::*;
(
    input  word_t    w0,
    input  word_t    w1,
    input  word_t    w2,
    input  word_t    w3,
    input  word_t    rk,
    input  mix_sel_t mix_sel,
    output word_t    nw
);

    word_t t;
    word_t s;
    word_t m;

    assign t = w1 ^ w2 ^ w3 ^ rk;

    always_comb begin
        for (int b = 0; b < 4; b++) begin
            s[8*b +: 8] = SBOX[t[8*b +: 8]];
        end
    end

    always_comb begin
        unique case (mix_sel)
            MIX_KEY: m = s ^ {s[18:0], s[31:19]} ^ {s[8:0], s[31:9]};
            MIX_DATA: m = s ^ {s[29:0], s[31:30]} ^ {s[21:0], s[31:22]}
                        ^ {s[13:0], s[31:14]} ^ {s[7:0], s[31:8]};
            default: m = s;
        endcase
    end

    assign nw = w0 ^ m;

endmodule

// File: hdl/sm4_block_encrypt.sv
// SM4 block encryption top level: key registers, key schedule, round sequencer.
//
//   channel | direction | payload (low bits first)
//   s_      | in        | plain_high[63:0], plain_low[127:64]
//   m_      | out       | cipher_high[63:0], cipher_low[127:64]
//   APB     | in        | key_high at 0x0, key_low at 0x8
//
// A block is loaded and then runs its 32 rounds through one shared round unit.
// After reset, and after each key write, the key schedule loads the key and runs on the
// same round unit, writing the 32-entry round key file; s_tready stays low meanwhile.
// A finished block sits in the output register; the next block is accepted, and
// its last round holds until the output register is free.
module sm4_block_encrypt
    import sm4_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // plain_high[63:0], plain_low[127:64]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // cipher_high[63:0], cipher_low[127:64]
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);

    typedef enum logic [1:0] {
        ST_KLOAD,
        ST_KEXP,
        ST_IDLE,
        ST_ENC
    } state_t;

    localparam round_idx_t LAST_ROUND = round_idx_t'(ROUND_COUNT - 1);

    state_t       state_reg, state_next;
    round_idx_t   cnt_reg, cnt_next;
    word_t        work_reg [4];
    word_t        work_next [4];
    word_t        rk_reg [ROUND_COUNT];
    logic [63:0]  key_high_reg, key_low_reg;
    logic         m_valid_reg, m_valid_next;
    logic [127:0] m_data_reg, m_data_next;
    logic         rk_we;
    logic         key_write;
    logic         out_free;
    word_t        round_key;
    word_t        nw;
    mix_sel_t     mix_sel;

    assign pready    = 1'b1;
    assign key_write = psel & penable & pwrite & pready;
    assign prdata    = paddr[3] ? key_low_reg : key_high_reg;
    assign s_tready  = (state_reg == ST_IDLE) && !key_write;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign out_free  = !m_valid_reg || m_tready;

    assign mix_sel   = (state_reg == ST_KEXP) ? MIX_KEY : MIX_DATA;
    assign round_key = (state_reg == ST_KEXP) ? ck_word(cnt_reg) : rk_reg[cnt_reg];

    sm4_round u_round (
        .w0      (work_reg[0]),
        .w1      (work_reg[1]),
        .w2      (work_reg[2]),
        .w3      (work_reg[3]),
        .rk      (round_key),
        .mix_sel (mix_sel),
        .nw      (nw)
    );

    always_comb begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        work_next    = work_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        rk_we        = 1'b0;
        unique case (state_reg)
            ST_KLOAD: begin
                work_next[0] = key_high_reg[63:32] ^ FK0;
                work_next[1] = key_high_reg[31:0]  ^ FK1;
                work_next[2] = key_low_reg[63:32]  ^ FK2;
                work_next[3] = key_low_reg[31:0]   ^ FK3;
                cnt_next     = '0;
                state_next   = ST_KEXP;
            end
            ST_KEXP: begin
                work_next = '{work_reg[1], work_reg[2], work_reg[3], nw};
                rk_we     = 1'b1;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == LAST_ROUND) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    work_next[0] = s_tdata[63:32];
                    work_next[1] = s_tdata[31:0];
                    work_next[2] = s_tdata[127:96];
                    work_next[3] = s_tdata[95:64];
                    cnt_next     = '0;
                    state_next   = ST_ENC;
                end
            end
            ST_ENC: begin
                if (cnt_reg != LAST_ROUND) begin
                    work_next = '{work_reg[1], work_reg[2], work_reg[3], nw};
                    cnt_next  = cnt_reg + 1'b1;
                end else if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {work_reg[2], work_reg[1], nw, work_reg[3]};
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_KLOAD;
        endcase
        if (key_write) begin
            state_next = ST_KLOAD;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_KLOAD;
            cnt_reg      <= '0;
            m_valid_reg  <= 1'b0;
            key_high_reg <= '0;
            key_low_reg  <= '0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            if (key_write) begin
                if (paddr[3]) begin
                    key_low_reg <= pwdata;
                end else begin
                    key_high_reg <= pwdata;
                end
            end
        end
        work_reg   <= work_next;
        m_data_reg <= m_data_next;
        if (rk_we) begin
            rk_reg[cnt_reg] <= nw;
        end
    end

endmodule
